### hdl/tse_pkg.sv
// Shared constants and types for the three-sector encoder position tracker.
// No dependencies; used by every other file of the block.
package tse_pkg;

	localparam int POSITION_BITS_DEF = 16;
	localparam int TICKS_W           = 15;
	localparam int TICK_OUT_W        = 16;
	localparam int ANGLE_W           = 25;
	localparam int DEG_PER_REV       = 360;
	localparam int DEG_MUL_W         = 9;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_CW   = 2'd1;
	localparam logic [1:0] DIR_CCW  = 2'd2;

	localparam logic [1:0] SECTOR_NONE  = 2'd0;
	localparam logic [1:0] SECTOR_ONE   = 2'd1;
	localparam logic [1:0] SECTOR_TWO   = 2'd2;
	localparam logic [1:0] SECTOR_THREE = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### hdl/tse_if.sv
// Valid/ready channel interfaces for sensor samples and position results.
// Depends on tse_pkg for field widths.
interface tse_sample_if;
	logic valid;
	logic ready;
	logic sensor_one_n;
	logic sensor_two_n;
	logic sensor_three_n;

	modport source(output valid, sensor_one_n, sensor_two_n, sensor_three_n, input ready);
	modport sink(input valid, sensor_one_n, sensor_two_n, sensor_three_n, output ready);
endinterface

interface tse_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [tse_pkg::TICK_OUT_W-1:0] tick_position;
	logic signed [tse_pkg::ANGLE_W-1:0]    angle_degrees;
	logic [1:0]                         rotation_dir;
	logic [1:0]                         active_sector;
	logic                               moved;

	modport source(output valid, tick_position, angle_degrees, rotation_dir, active_sector,
		moved, input ready);
	modport sink(input valid, tick_position, angle_degrees, rotation_dir, active_sector,
		moved, output ready);
endinterface

### hdl/tse_tracker.sv
// Sector decode, direction and signed tick position state.
// Depends on tse_pkg for sector and direction codes.
module tse_tracker #(
	parameter int POSITION_BITS = tse_pkg::POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic                     sensor_one_n,
	input  logic                     sensor_two_n,
	input  logic                     sensor_three_n,
	output logic [1:0]               sector,
	output logic [1:0]               direction,
	output logic [POSITION_BITS-1:0] position,
	output logic                     moved
);

	logic [1:0]               sector_q;
	logic [1:0]               dir_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     moved_q;
	logic [1:0]               now_sector;
	logic [1:0]               dir_next;
	logic                     cw;
	logic                     ccw;

	always_comb begin
		now_sector = sector_q;
		if (!sensor_one_n)   now_sector = tse_pkg::SECTOR_ONE;
		if (!sensor_two_n)   now_sector = tse_pkg::SECTOR_TWO;
		if (!sensor_three_n) now_sector = tse_pkg::SECTOR_THREE;

		cw = (sector_q == tse_pkg::SECTOR_ONE   && now_sector == tse_pkg::SECTOR_TWO)   ||
		     (sector_q == tse_pkg::SECTOR_TWO   && now_sector == tse_pkg::SECTOR_THREE) ||
		     (sector_q == tse_pkg::SECTOR_THREE && now_sector == tse_pkg::SECTOR_ONE);
		ccw = (sector_q == tse_pkg::SECTOR_TWO   && now_sector == tse_pkg::SECTOR_ONE)   ||
		      (sector_q == tse_pkg::SECTOR_THREE && now_sector == tse_pkg::SECTOR_TWO)   ||
		      (sector_q == tse_pkg::SECTOR_ONE   && now_sector == tse_pkg::SECTOR_THREE);

		dir_next = dir_q;
		if (cw)       dir_next = tse_pkg::DIR_CW;
		else if (ccw) dir_next = tse_pkg::DIR_CCW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sector_q <= tse_pkg::SECTOR_NONE;
			dir_q    <= tse_pkg::DIR_NONE;
			pos_q    <= '0;
			moved_q  <= 1'b0;
		end else if (accept) begin
			moved_q <= (now_sector != sector_q);
			if (now_sector != sector_q) begin
				sector_q <= now_sector;
				dir_q    <= dir_next;
				if (dir_next == tse_pkg::DIR_CW)
					pos_q <= pos_q + POSITION_BITS'(1);
				else if (dir_next == tse_pkg::DIR_CCW)
					pos_q <= pos_q - POSITION_BITS'(1);
			end
		end
	end

	assign sector    = sector_q;
	assign direction = dir_q;
	assign position  = pos_q;
	assign moved     = moved_q;

endmodule

### hdl/tse_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on tse_pkg for the divisor width and status struct.
module tse_divider #(
	parameter int DIVIDEND_W = tse_pkg::POSITION_BITS_DEF + tse_pkg::DEG_MUL_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DIVIDEND_W-1:0]         dividend,
	input  logic [tse_pkg::TICKS_W-1:0]   divisor,
	output logic [DIVIDEND_W-1:0]         quotient,
	output tse_pkg::div_stat_t            stat
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0]       quo_q;
	logic [tse_pkg::TICKS_W-1:0] rem_q;
	logic [tse_pkg::TICKS_W-1:0] div_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tse_pkg::TICKS_W:0]   trial;
	logic [tse_pkg::TICKS_W:0]   diff;
	logic                        fits;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[tse_pkg::TICKS_W-1:0] : trial[tse_pkg::TICKS_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### hdl/three_sector_encoder_position.sv
// Three-sector rotary encoder position tracker: APB register, sequencer, output register.
// Depends on tse_pkg, tse_if, tse_tracker and tse_divider.
//
// Each accepted sample updates sector, direction and the signed tick position at once,
// then the angle in degrees is found by a serial divider that retires one quotient bit
// per cycle. After a transfer the sequencer runs a load state, the divider steps and a
// finish state that loads the output register, then returns to idle and takes the next
// sample; with ticks_per_rotation at zero the divider is skipped. The finish state waits
// while the output register holds a result not yet taken. The finished result sits in an
// output register, so the next sample is taken while it waits.
module three_sector_encoder_position #(
	parameter int POSITION_BITS = tse_pkg::POSITION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tse_sample_if.sink   sample,
	tse_result_if.source result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int DIV_W = POSITION_BITS + tse_pkg::DEG_MUL_W;
	localparam int SW    = DIV_W + 2;
	localparam int CW    = (SW > tse_pkg::ANGLE_W + 1) ? SW : tse_pkg::ANGLE_W + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	localparam logic [1:0] TICKS_ADDR = 2'd0;

	localparam logic signed [CW-1:0] DEG_MAX = CW'((1 << (tse_pkg::ANGLE_W - 1)) - 1);
	localparam logic signed [CW-1:0] DEG_MIN = -CW'(1 << (tse_pkg::ANGLE_W - 1));

	logic [1:0]                  state_q;
	logic [tse_pkg::TICKS_W-1:0] ticks_q;
	logic                        accept;
	logic                        div_start;
	logic                        load_out;

	logic [1:0]               trk_sector;
	logic [1:0]               trk_dir;
	logic [POSITION_BITS-1:0] trk_pos;
	logic                     trk_moved;

	logic [POSITION_BITS-1:0] pos_mag;
	logic [DIV_W-1:0]         dividend;
	logic [DIV_W-1:0]         quotient;
	tse_pkg::div_stat_t       div_stat;

	logic signed [CW-1:0]     deg_full;
	logic signed [CW-1:0]     deg_sat;

	logic                               out_valid_q;
	logic signed [tse_pkg::TICK_OUT_W-1:0] tick_q;
	logic signed [tse_pkg::ANGLE_W-1:0]    angle_q;
	logic [1:0]                         dir_q;
	logic [1:0]                         sector_q;
	logic                               moved_q;

	// configuration
	assign pready = 1'b1;
	assign prdata = {{(32 - tse_pkg::TICKS_W){1'b0}}, ticks_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
		end else if (psel && penable && pwrite && paddr == TICKS_ADDR) begin
			ticks_q <= pwdata[tse_pkg::TICKS_W-1:0];
		end
	end

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;

	tse_tracker #(.POSITION_BITS(POSITION_BITS)) u_tracker (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.sensor_one_n  (sample.sensor_one_n),
		.sensor_two_n  (sample.sensor_two_n),
		.sensor_three_n(sample.sensor_three_n),
		.sector        (trk_sector),
		.direction     (trk_dir),
		.position      (trk_pos),
		.moved         (trk_moved)
	);

	always_comb begin
		pos_mag  = trk_pos[POSITION_BITS-1] ? (~trk_pos + POSITION_BITS'(1)) : trk_pos;
		dividend = DIV_W'(pos_mag) * DIV_W'(tse_pkg::DEG_PER_REV);
	end

	assign div_start = (state_q == S_LOAD) && (ticks_q != '0);

	tse_divider #(.DIVIDEND_W(DIV_W)) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (ticks_q),
		.quotient(quotient),
		.stat    (div_stat)
	);

	// zero with no tick count, offset from 360 for negative positions, saturate to the output range
	always_comb begin
		if (ticks_q == '0)
			deg_full = '0;
		else if (trk_pos[POSITION_BITS-1])
			deg_full = CW'(tse_pkg::DEG_PER_REV) - CW'(quotient);
		else
			deg_full = CW'(quotient);
		if (deg_full > DEG_MAX)
			deg_sat = DEG_MAX;
		else if (deg_full < DEG_MIN)
			deg_sat = DEG_MIN;
		else
			deg_sat = deg_full;
	end

	assign load_out = (state_q == S_FIN) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_LOAD;
				S_LOAD: state_q <= (ticks_q != '0) ? S_DIV : S_FIN;
				S_DIV:  if (div_stat.done) state_q <= S_FIN;
				S_FIN:  if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			tick_q   <= tse_pkg::TICK_OUT_W'({{tse_pkg::TICK_OUT_W{1'b0}}, trk_pos});
			angle_q  <= deg_sat[tse_pkg::ANGLE_W-1:0];
			dir_q    <= trk_dir;
			sector_q <= trk_sector;
			moved_q  <= trk_moved;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.tick_position = tick_q;
	assign result.angle_degrees = angle_q;
	assign result.rotation_dir  = dir_q;
	assign result.active_sector = sector_q;
	assign result.moved         = moved_q;

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_LOAD) else $error("transfer did not start load");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV) else $error("divider done outside divide");
	a_busy_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == S_DIV) else $error("divider busy outside divide");
	a_moved_sector: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.moved |-> result.active_sector != tse_pkg::SECTOR_NONE)
		else $error("move reported with no sector");
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.rotation_dir != 2'd3) else $error("bad direction code");

endmodule
